FILE: rtl/msa_pkg.sv
// msa_pkg: shared types, constants and the microprogram of the mahalanobis accumulator
// used by msa_apb_regs and mahalanobis_sqrt_accumulator_unit; no dependencies
package msa_pkg;

    localparam int ROT_W    = 16;
    localparam int N_ROT    = 9;
    localparam int FIELD_W  = 32;
    localparam int IN_W     = 9 * FIELD_W;
    localparam int OUT_W    = 48;
    localparam int APB_W    = 64;
    localparam int ADDR_W   = 5;
    localparam int VW       = 38;
    localparam int CW       = 77;
    localparam int MB_W     = 64;
    localparam int SAR_BITS = 28;
    localparam int PROG_LEN = 166;
    localparam int PC_W     = 8;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [3:0] OP_CLR   = 4'd0;
    localparam logic [3:0] OP_MUL   = 4'd1;
    localparam logic [3:0] OP_MOVT  = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_ADDA  = 4'd5;
    localparam logic [3:0] OP_SAR   = 4'd6;
    localparam logic [3:0] OP_STV   = 4'd7;
    localparam logic [3:0] OP_STC   = 4'd8;
    localparam logic [3:0] OP_STDET = 4'd9;
    localparam logic [3:0] OP_END   = 4'd10;

    localparam logic [2:0] SRC_ROT = 3'd0;
    localparam logic [2:0] SRC_VA  = 3'd1;
    localparam logic [2:0] SRC_VB  = 3'd2;
    localparam logic [2:0] SRC_V   = 3'd3;
    localparam logic [2:0] SRC_C   = 3'd4;
    localparam logic [2:0] SRC_E   = 3'd5;
    localparam logic [2:0] SRC_T   = 3'd6;

    localparam logic [1:0] REG_ROT_LOW  = 2'd0;
    localparam logic [1:0] REG_ROT_MID  = 2'd1;
    localparam logic [1:0] REG_ROT_HIGH = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] atype;
        logic [3:0] aidx;
        logic [2:0] btype;
        logic [3:0] bidx;
        logic [6:0] nb;
    } t_uop;

    typedef t_uop [PROG_LEN-1:0] t_prog;
    typedef logic [N_ROT-1:0][ROT_W-1:0] t_rot;

    function automatic t_uop mk_uop(logic [3:0] op, logic [2:0] at, int ai,
                                    logic [2:0] bt, int bi, int nb);
        t_uop u;
        u.op    = op;
        u.atype = at;
        u.aidx  = 4'(ai);
        u.btype = bt;
        u.bidx  = 4'(bi);
        u.nb    = 7'(nb);
        return u;
    endfunction

    // index of a symmetric 3x3 entry: 00 01 02 11 12 22
    function automatic int sym_idx(int i, int j);
        int a;
        int b;
        a = (i < j) ? i : j;
        b = (i < j) ? j : i;
        if (a == 0) return b;
        else if (a == 1) return 2 + b;
        else return 5;
    endfunction

    function automatic t_prog build_prog();
        t_prog p;
        int n;
        int i1;
        int i2;
        int j1;
        int j2;
        p = '0;
        n = 0;
        // covariance entries
        for (int i = 0; i < 3; i++) begin
            for (int j = i; j < 3; j++) begin
                p[n] = mk_uop(OP_CLR, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                for (int k = 0; k < 3; k++) begin
                    p[n] = mk_uop(OP_MUL, SRC_ROT, 3*k+i, SRC_ROT, 3*k+j, ROT_W); n++;
                    p[n] = mk_uop(OP_MOVT, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                    p[n] = mk_uop(OP_MUL, SRC_VA, k, SRC_T, 0, 32); n++;
                    p[n] = mk_uop(OP_ADD, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                end
                p[n] = mk_uop(OP_SAR, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                if (i == j) begin
                    p[n] = mk_uop(OP_ADDA, SRC_VB, i, SRC_ROT, 0, 0); n++;
                end
                p[n] = mk_uop(OP_STV, SRC_V, sym_idx(i, j), SRC_ROT, 0, 0); n++;
            end
        end
        // cofactors
        for (int i = 0; i < 3; i++) begin
            for (int j = i; j < 3; j++) begin
                i1 = (i + 1) % 3;
                i2 = (i + 2) % 3;
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                p[n] = mk_uop(OP_CLR, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                p[n] = mk_uop(OP_MUL, SRC_V, sym_idx(i1, j1), SRC_V, sym_idx(i2, j2), VW); n++;
                p[n] = mk_uop(OP_ADD, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                p[n] = mk_uop(OP_MUL, SRC_V, sym_idx(i1, j2), SRC_V, sym_idx(i2, j1), VW); n++;
                p[n] = mk_uop(OP_SUB, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                p[n] = mk_uop(OP_STC, SRC_C, sym_idx(i, j), SRC_ROT, 0, 0); n++;
            end
        end
        // determinant
        p[n] = mk_uop(OP_CLR, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
        for (int j = 0; j < 3; j++) begin
            p[n] = mk_uop(OP_MUL, SRC_C, sym_idx(0, j), SRC_V, sym_idx(0, j), VW); n++;
            p[n] = mk_uop(OP_ADD, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
        end
        p[n] = mk_uop(OP_STDET, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
        // quadratic form, off-diagonal terms counted twice
        p[n] = mk_uop(OP_CLR, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
        for (int i = 0; i < 3; i++) begin
            for (int j = i; j < 3; j++) begin
                p[n] = mk_uop(OP_MUL, SRC_E, i, SRC_E, j, 32); n++;
                p[n] = mk_uop(OP_MOVT, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                p[n] = mk_uop(OP_MUL, SRC_C, sym_idx(i, j), SRC_T, 0, MB_W); n++;
                p[n] = mk_uop(OP_ADD, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                if (i != j) begin
                    p[n] = mk_uop(OP_ADD, SRC_ROT, 0, SRC_ROT, 0, 0); n++;
                end
            end
        end
        p[n] = mk_uop(OP_END, SRC_ROT, 0, SRC_ROT, 0, 0);
        return p;
    endfunction

    localparam t_prog PROG = build_prog();

endpackage

FILE: rtl/mahalanobis_sqrt_accumulator_unit.sv
// mahalanobis_sqrt_accumulator_unit: top level, microcoded sequencer around one shared adder
// depends on msa_pkg and msa_apb_regs
//
// Usage: points arrive on the s channel (tdata holds err_x..z, var_a_x..z, var_b_x..z,
// tlast marks the last point of a run). Each point forms the rotated covariance,
// its adjugate and determinant, the quadratic form, a restoring division and a
// restoring square root, all through one W-bit add/subtract unit driven by a
// microprogram; W = 146 + FRAC_BITS rounded up to even.
// Each point runs the microcode steps, each multiply step as a bit-serial
// multiply, then the restoring divide and root, plus check, sum, finish and
// idle; a point skipped as bad goes from check straight to finish and
// skips the divide, root and sum. s_tready is high only
// while no point is in work. On a last point the saturated sum and bad flag
// are loaded into the m channel output register and the running sum clears;
// if the receiver stalls, the next point is still taken and worked on, and only
// a following last point waits for the register to drain.
// Reset clears the sum, the flag, the sequencer and the output valid; the
// rotation registers return to identity.
module mahalanobis_sqrt_accumulator_unit #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // err_x, err_y, err_z, var_a_x, var_a_y, var_a_z, var_b_x, var_b_y, var_b_z
    input  logic [msa_pkg::IN_W-1:0]    i_s_tdata,
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // distance_sum
    output logic [msa_pkg::OUT_W-1:0]   o_m_tdata,
    // bad_point_seen
    output logic                        o_m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msa_pkg::ADDR_W-1:0]  paddr,
    input  logic [msa_pkg::APB_W-1:0]   pwdata,
    output logic [msa_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import msa_pkg::*;

    localparam int W     = 146 + FRAC_BITS + (FRAC_BITS % 2);
    localparam int RW    = W / 2;
    localparam int CNT_W = $clog2(W);
    localparam int XW    = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    t_rot rot;

    logic [2:0]           r_state, n_state;
    logic [PC_W-1:0]      r_pc, n_pc;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [MB_W-1:0]      r_mb, n_mb;
    logic [W-1:0]         r_p, n_p;
    logic [W-1:0]         r_acc, n_acc;
    logic [MB_W-1:0]      r_t, n_t;
    logic [VW-1:0]        r_v [6];
    logic [VW-1:0]        n_v [6];
    logic [CW-1:0]        r_c [6];
    logic [CW-1:0]        n_c [6];
    logic [W-1:0]         r_det, n_det;
    logic [RW-1:0]        r_root, n_root;
    logic [ACC_WIDTH-1:0] r_sum, n_sum;
    logic                 r_bad, n_bad;
    logic                 r_last, n_last;
    logic [FIELD_W-1:0]   r_e [3];
    logic [FIELD_W-1:0]   n_e [3];
    logic [FIELD_W-1:0]   r_va [3];
    logic [FIELD_W-1:0]   n_va [3];
    logic [FIELD_W-1:0]   r_vb [3];
    logic [FIELD_W-1:0]   n_vb [3];
    logic                 r_ovalid, n_ovalid;
    logic [OUT_W-1:0]     r_osum, n_osum;
    logic                 r_obad, n_obad;

    t_uop                 cur;
    logic [2:0]           sel_t;
    logic [3:0]           sel_i;
    logic [W-1:0]         opnd;
    logic [W-1:0]         base;
    logic [W-1:0]         y;
    logic                 sub;
    logic [W-1:0]         alu_res;
    logic                 res_neg;
    logic                 mul_first;
    logic                 bad_now;
    logic [ACC_WIDTH-1:0] term;
    logic [ACC_WIDTH:0]   sum_ext;
    logic [XW-1:0]        sum_wide;
    logic                 in_acc;

    msa_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rot   (rot)
    );

    assign cur        = PROG[r_pc];
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_osum;
    assign o_m_tuser  = r_obad;

    // operand select, b side only on the load cycle of a multiply
    always_comb begin
        if (r_state == S_RUN && cur.op == OP_MUL) begin
            sel_t = cur.btype;
            sel_i = cur.bidx;
        end else begin
            sel_t = cur.atype;
            sel_i = cur.aidx;
        end
        case (sel_t)
            SRC_ROT: opnd = {{(W-ROT_W){rot[sel_i][ROT_W-1]}}, rot[sel_i]};
            SRC_VA:  opnd = {{(W-FIELD_W){1'b0}}, r_va[sel_i[1:0]]};
            SRC_VB:  opnd = {{(W-FIELD_W){1'b0}}, r_vb[sel_i[1:0]]};
            SRC_V:   opnd = {{(W-VW){r_v[sel_i[2:0]][VW-1]}}, r_v[sel_i[2:0]]};
            SRC_C:   opnd = {{(W-CW){r_c[sel_i[2:0]][CW-1]}}, r_c[sel_i[2:0]]};
            SRC_E:   opnd = {{(W-FIELD_W){r_e[sel_i[1:0]][FIELD_W-1]}}, r_e[sel_i[1:0]]};
            SRC_T:   opnd = {{(W-MB_W){r_t[MB_W-1]}}, r_t};
            default: opnd = '0;
        endcase
    end

    // shared add/subtract unit
    always_comb begin
        mul_first = (r_cnt == CNT_W'(cur.nb) - CNT_W'(1));
        base = r_acc;
        y    = r_p;
        sub  = 1'b0;
        case (r_state)
            S_RUN: begin
                if (cur.op == OP_SUB) begin
                    sub = 1'b1;
                end else if (cur.op == OP_ADDA) begin
                    y = opnd;
                end
            end
            S_MUL: begin
                base = {r_p[W-2:0], 1'b0};
                y    = r_mb[r_cnt[5:0]] ? opnd : '0;
                sub  = mul_first;
            end
            S_DIV: begin
                base = {r_p[W-2:0], r_acc[W-1]};
                y    = r_det;
                sub  = 1'b1;
            end
            S_SQRT: begin
                base = {r_p[W-3:0], r_acc[W-1:W-2]};
                y    = W'({r_root, 2'b01});
                sub  = 1'b1;
            end
            default: ;
        endcase
        alu_res = base + (sub ? ~y : y) + W'(sub);
        res_neg = alu_res[W-1];
    end

    always_comb begin
        bad_now  = r_det[W-1] || (r_det == '0) || r_acc[W-1];
        term     = (|r_root[RW-1:ACC_WIDTH]) ? '1 : r_root[ACC_WIDTH-1:0];
        sum_ext  = {1'b0, r_sum} + {1'b0, term};
        sum_wide = XW'(r_sum);
    end

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        n_mb     = r_mb;
        n_p      = r_p;
        n_acc    = r_acc;
        n_t      = r_t;
        n_v      = r_v;
        n_c      = r_c;
        n_det    = r_det;
        n_root   = r_root;
        n_sum    = r_sum;
        n_bad    = r_bad;
        n_last   = r_last;
        n_e      = r_e;
        n_va     = r_va;
        n_vb     = r_vb;
        n_ovalid = r_ovalid;
        n_osum   = r_osum;
        n_obad   = r_obad;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        n_e[i]  = i_s_tdata[FIELD_W*i +: FIELD_W];
                        n_va[i] = i_s_tdata[FIELD_W*(i+3) +: FIELD_W];
                        n_vb[i] = i_s_tdata[FIELD_W*(i+6) +: FIELD_W];
                    end
                    n_last  = i_s_tlast;
                    n_pc    = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_pc = r_pc + PC_W'(1);
                case (cur.op)
                    OP_CLR:   n_acc = '0;
                    OP_MUL: begin
                        n_mb    = opnd[MB_W-1:0];
                        n_p     = '0;
                        n_cnt   = CNT_W'(cur.nb) - CNT_W'(1);
                        n_pc    = r_pc;
                        n_state = S_MUL;
                    end
                    OP_MOVT:  n_t = r_p[MB_W-1:0];
                    OP_ADD,
                    OP_SUB,
                    OP_ADDA:  n_acc = alu_res;
                    OP_SAR:   n_acc = W'($signed(r_acc) >>> SAR_BITS);
                    OP_STV:   n_v[cur.aidx[2:0]] = r_acc[VW-1:0];
                    OP_STC:   n_c[cur.aidx[2:0]] = r_acc[CW-1:0];
                    OP_STDET: n_det = r_acc;
                    OP_END: begin
                        n_pc    = r_pc;
                        n_state = S_CHECK;
                    end
                    default: ;
                endcase
            end
            S_MUL: begin
                n_p = alu_res;
                if (r_cnt == '0) begin
                    n_pc    = r_pc + PC_W'(1);
                    n_state = S_RUN;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_CHECK: begin
                if (bad_now) begin
                    n_bad   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_acc   = r_acc << FRAC_BITS;
                    n_p     = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_p   = res_neg ? base : alu_res;
                n_acc = {r_acc[W-2:0], ~res_neg};
                if (r_cnt == '0) begin
                    n_p     = '0;
                    n_cnt   = CNT_W'(RW - 1);
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_SQRT: begin
                n_p    = res_neg ? base : alu_res;
                n_root = {r_root[RW-2:0], ~res_neg};
                n_acc  = {r_acc[W-3:0], 2'b00};
                if (r_cnt == '0) begin
                    n_state = S_SUM;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_SUM: begin
                n_sum   = sum_ext[ACC_WIDTH] ? '1 : sum_ext[ACC_WIDTH-1:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_osum   = (sum_wide > XW'(OUT_MAX)) ? OUT_MAX : sum_wide[OUT_W-1:0];
                    n_obad   = r_bad;
                    n_sum    = '0;
                    n_bad    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_bad    <= n_bad;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mb   <= n_mb;
        r_p    <= n_p;
        r_acc  <= n_acc;
        r_t    <= n_t;
        r_v    <= n_v;
        r_c    <= n_c;
        r_det  <= n_det;
        r_root <= n_root;
        r_last <= n_last;
        r_e    <= n_e;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_osum <= n_osum;
        r_obad <= n_obad;
    end

    // divide only starts on a positive determinant
    a_div_det_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (!r_det[W-1] && r_det != '0))
        else $error("divide running on a non-positive determinant");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_MUL) |-> (r_pc < PC_W'(PROG_LEN)))
        else $error("microprogram counter out of range");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !$past(r_ovalid)) |-> $past(r_state == S_FIN && r_last))
        else $error("result raised without a last point");

    a_start_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RUN && r_pc == '0))
        else $error("accepted transaction did not start the microprogram");

endmodule

FILE: rtl/msa_apb_regs.sv
// msa_apb_regs: apb configuration registers holding the 3x3 rotation
// depends on msa_pkg
module msa_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msa_pkg::ADDR_W-1:0]   paddr,
    input  logic [msa_pkg::APB_W-1:0]    pwdata,
    output logic [msa_pkg::APB_W-1:0]    prdata,
    output logic                         pready,
    output msa_pkg::t_rot                o_rot
);
    import msa_pkg::*;

    localparam logic [APB_W-1:0] ROT_RESET = APB_W'(16384);

    logic [APB_W-1:0] r_rot_low;
    logic [APB_W-1:0] r_rot_mid;
    logic [ROT_W-1:0] r_rot_high;
    logic [1:0]       reg_sel;
    logic             wr_en;

    assign reg_sel = paddr[ADDR_W-1:ADDR_W-2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_low  <= ROT_RESET;
            r_rot_mid  <= ROT_RESET;
            r_rot_high <= ROT_RESET[ROT_W-1:0];
        end else if (wr_en) begin
            case (reg_sel)
                REG_ROT_LOW:  r_rot_low  <= pwdata;
                REG_ROT_MID:  r_rot_mid  <= pwdata;
                REG_ROT_HIGH: r_rot_high <= pwdata[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROT_LOW:  prdata = r_rot_low;
            REG_ROT_MID:  prdata = r_rot_mid;
            REG_ROT_HIGH: prdata = APB_W'(r_rot_high);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            o_rot[n]     = r_rot_low[ROT_W*n +: ROT_W];
            o_rot[n + 4] = r_rot_mid[ROT_W*n +: ROT_W];
        end
        o_rot[8] = r_rot_high;
    end

endmodule
